FILE: src/hsps_pkg.sv
package hsps_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned AddrW    = 5;

  localparam logic [2:0] RegCycle    = 3'd0;
  localparam logic [2:0] RegTempDly  = 3'd1;
  localparam logic [2:0] RegHumDly   = 3'd2;
  localparam logic [2:0] RegCrcPoly  = 3'd3;
  localparam logic [2:0] RegCrcSeed  = 3'd4;
  localparam logic [2:0] RegStatMask = 3'd5;

  localparam logic [1:0] CmdNone = 2'd0;
  localparam logic [1:0] CmdTemp = 2'd1;
  localparam logic [1:0] CmdHum  = 2'd2;

  localparam logic [1:0] PhCodeIdle = 2'd0;
  localparam logic [1:0] PhCodeTemp = 2'd1;
  localparam logic [1:0] PhCodeHum  = 2'd2;
  localparam logic [1:0] PhCodeBad  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_TEMP = 3'b010,
    PH_HUM  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [15:0] cycle_ms;
    logic [7:0]  temp_delay_ms;
    logic [7:0]  hum_delay_ms;
    logic [7:0]  crc_poly;
    logic [7:0]  crc_seed;
    logic [7:0]  status_mask;
  } cfg_t;

  typedef struct packed {
    logic [ElapsedW-1:0] elapsed_ms;
    logic                write_ok;
    logic                read_ok;
    logic [ByteW-1:0]    msb_byte;
    logic [ByteW-1:0]    lsb_byte;
    logic [ByteW-1:0]    crc_byte;
    logic [ByteW-1:0]    crc_hi;
  } item_t;

  typedef struct packed {
    logic [1:0]       issued_cmd;
    logic             issued_read;
    logic             step_ok;
    logic             checksum_bad;
    logic [CodeW-1:0] temp_code;
    logic [CodeW-1:0] hum_code;
    logic [1:0]       phase;
  } result_t;

endpackage

FILE: src/humidity_sensor_poll_sequencer_core.sv
// A request is taken into the input register; once the output register is free or being
// drained, its result lands in the output register, which drives tvalid on the master side.
// Throughput: one request per cycle unless m_axis_tready stalls, set by the state update loop.
// Reset (rst_ni, asynchronous, active low) sets the idle phase with first entry pending,
// clears the elapsed total and both codes, and loads the configuration defaults.
module humidity_sensor_poll_sequencer_core
  import hsps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // elapsed_ms, write_ok, read_ok, msb_byte, lsb_byte, crc_byte (from bit 0 up)
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // issued_cmd, issued_read, step_ok, checksum_bad, temp_code, hum_code, phase
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t             cfg_q;
  logic             s1_valid_q;
  item_t            s1_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_d;
  logic             advance;
  logic             in_take;
  logic [ByteW-1:0] crc_hi;
  logic [ByteW-1:0] crc_full;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycle_ms      <= 16'd1000;
      cfg_q.temp_delay_ms <= 8'd50;
      cfg_q.hum_delay_ms  <= 8'd16;
      cfg_q.crc_poly      <= 8'h31;
      cfg_q.crc_seed      <= 8'h00;
      cfg_q.status_mask   <= 8'h02;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        RegCycle:    cfg_q.cycle_ms      <= pwdata[15:0];
        RegTempDly:  cfg_q.temp_delay_ms <= pwdata[7:0];
        RegHumDly:   cfg_q.hum_delay_ms  <= pwdata[7:0];
        RegCrcPoly:  cfg_q.crc_poly      <= pwdata[7:0];
        RegCrcSeed:  cfg_q.crc_seed      <= pwdata[7:0];
        RegStatMask: cfg_q.status_mask   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCycle:    prdata = {16'h0000, cfg_q.cycle_ms};
      RegTempDly:  prdata = {24'h000000, cfg_q.temp_delay_ms};
      RegHumDly:   prdata = {24'h000000, cfg_q.hum_delay_ms};
      RegCrcPoly:  prdata = {24'h000000, cfg_q.crc_poly};
      RegCrcSeed:  prdata = {24'h000000, cfg_q.crc_seed};
      RegStatMask: prdata = {24'h000000, cfg_q.status_mask};
      default:     prdata = '0;
    endcase
  end

  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  hsps_crc8_byte u_crc_hi (
    .crc_i  (cfg_q.crc_seed),
    .byte_i (s_axis_tdata[25:18]),
    .poly_i (cfg_q.crc_poly),
    .crc_o  (crc_hi)
  );

  hsps_crc8_byte u_crc_lo (
    .crc_i  (s1_q.crc_hi),
    .byte_i (s1_q.lsb_byte),
    .poly_i (cfg_q.crc_poly),
    .crc_o  (crc_full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.elapsed_ms <= s_axis_tdata[15:0];
      s1_q.write_ok   <= s_axis_tdata[16];
      s1_q.read_ok    <= s_axis_tdata[17];
      s1_q.msb_byte   <= s_axis_tdata[25:18];
      s1_q.lsb_byte   <= s_axis_tdata[33:26];
      s1_q.crc_byte   <= s_axis_tdata[41:34];
      s1_q.crc_hi     <= crc_hi;
    end
  end

  hsps_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (s1_q),
    .crc_calc_i (crc_full),
    .cfg_i      (cfg_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.phase, res_q.hum_code, res_q.temp_code,
                          res_q.checksum_bad, res_q.step_ok, res_q.issued_read,
                          res_q.issued_cmd};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.checksum_bad |-> res_q.issued_read && !res_q.step_ok)
    else $error("checksum error reported without a failed read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.issued_cmd != CmdNone |-> !res_q.issued_read)
    else $error("command and frame read in the same request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_q.elapsed_ms == '0 |=>
      out_valid_q && res_q.issued_cmd == CmdNone && !res_q.issued_read && res_q.step_ok)
    else $error("idle request caused bus activity");

endmodule

FILE: src/hsps_crc8_byte.sv
module hsps_crc8_byte
  import hsps_pkg::*;
(
  input  logic [ByteW-1:0] crc_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] poly_i,
  output logic [ByteW-1:0] crc_o
);

  always_comb begin
    logic [ByteW-1:0] c;
    c = crc_i ^ byte_i;
    for (int b = 0; b < ByteW; b++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

FILE: src/hsps_step.sv
module hsps_step
  import hsps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  item_t            item_i,
  input  logic [ByteW-1:0] crc_calc_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  phase_e             phase_q, phase_d;
  logic               first_q, first_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [CodeW-1:0]   temp_q, temp_d;
  logic [CodeW-1:0]   hum_q, hum_d;

  always_comb begin
    logic [TotalW:0]    sum;
    logic [TotalW-1:0]  acc;
    logic [ByteW-1:0]   delay;
    logic [CodeW-1:0]   code;
    phase_d = phase_q;
    first_d = first_q;
    total_d = total_q;
    temp_d  = temp_q;
    hum_d   = hum_q;
    res_o.issued_cmd   = CmdNone;
    res_o.issued_read  = 1'b0;
    res_o.step_ok      = 1'b1;
    res_o.checksum_bad = 1'b0;
    sum   = {1'b0, total_q} + {{(TotalW+1-ElapsedW){1'b0}}, item_i.elapsed_ms};
    acc   = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
    delay = (phase_q == PH_TEMP) ? cfg_i.temp_delay_ms : cfg_i.hum_delay_ms;
    code  = {item_i.msb_byte, item_i.lsb_byte};
    if (item_i.elapsed_ms != '0) begin
      total_d = acc;
      case (phase_q)
        PH_TEMP, PH_HUM: begin
          if (first_q) begin
            res_o.issued_cmd = (phase_q == PH_TEMP) ? CmdTemp : CmdHum;
            if (item_i.write_ok) begin
              total_d = '0;
              first_d = 1'b0;
            end else begin
              res_o.step_ok = 1'b0;
            end
          end else if ({{(TotalW-ByteW){1'b0}}, delay} <= acc) begin
            res_o.issued_read = 1'b1;
            if (!item_i.read_ok) begin
              res_o.step_ok = 1'b0;
            end else if (crc_calc_i != item_i.crc_byte) begin
              res_o.step_ok      = 1'b0;
              res_o.checksum_bad = 1'b1;
            end else if ((item_i.lsb_byte & cfg_i.status_mask) == cfg_i.status_mask) begin
              hum_d = code & ~{{(CodeW-ByteW){1'b0}}, cfg_i.status_mask};
            end else begin
              temp_d = code;
            end
            phase_d = (phase_q == PH_TEMP) ? PH_HUM : PH_IDLE;
            first_d = 1'b1;
          end
        end
        PH_IDLE: begin
          if (first_q) begin
            total_d = '0;
            first_d = 1'b0;
          end else if (acc >= {{(TotalW-ElapsedW){1'b0}}, cfg_i.cycle_ms}) begin
            phase_d = PH_TEMP;
            first_d = 1'b1;
          end
        end
        default: begin
          res_o.step_ok = 1'b0;
        end
      endcase
    end
    res_o.temp_code = temp_d;
    res_o.hum_code  = hum_d;
    case (phase_d)
      PH_IDLE: res_o.phase = PhCodeIdle;
      PH_TEMP: res_o.phase = PhCodeTemp;
      PH_HUM:  res_o.phase = PhCodeHum;
      default: res_o.phase = PhCodeBad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= 1'b1;
      total_q <= '0;
      temp_q  <= '0;
      hum_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
      total_q <= total_d;
      temp_q  <= temp_d;
      hum_q   <= hum_d;
    end
  end

endmodule

FILE: test/poll_result_checker.sv
module poll_result_checker
  import hsps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [InDataW-1:0]  req_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [AddrW-1:0]    paddr_i,
  input  logic [31:0]         pwdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ByteW-1:0]    crc_byte;
    logic [ByteW-1:0]    lsb_byte;
    logic [ByteW-1:0]    msb_byte;
    logic                read_ok;
    logic                write_ok;
    logic [ElapsedW-1:0] elapsed_ms;
  } poll_req_t;

  cfg_t             cfg;
  logic [1:0]       cur_phase;
  logic             first_entry;
  logic [TotalW-1:0] elapsed_total;
  logic [CodeW-1:0] temp_code;
  logic [CodeW-1:0] hum_code;
  result_t          expected_results[$];

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ cfg.crc_poly) : (c << 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= 40) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic predict_poll(input poll_req_t rq, output result_t res);
    logic [TotalW:0]   sum;
    logic [ByteW-1:0]  delay;
    logic [ByteW-1:0]  crc;
    res = '0;
    res.issued_cmd = CmdNone;
    res.step_ok = 1'b1;
    if (rq.elapsed_ms != '0) begin
      sum = {1'b0, elapsed_total} + rq.elapsed_ms;
      elapsed_total = sum[TotalW] ? '1 : sum[TotalW-1:0];
      if (cur_phase == PhCodeTemp || cur_phase == PhCodeHum) begin
        delay = (cur_phase == PhCodeTemp) ? cfg.temp_delay_ms : cfg.hum_delay_ms;
        if (first_entry) begin
          res.issued_cmd = (cur_phase == PhCodeTemp) ? CmdTemp : CmdHum;
          if (rq.write_ok) begin
            elapsed_total = '0;
            first_entry = 1'b0;
          end else begin
            res.step_ok = 1'b0;
          end
        end else if (delay <= elapsed_total) begin
          res.issued_read = 1'b1;
          if (!rq.read_ok) begin
            res.step_ok = 1'b0;
          end else begin
            crc = crc8_byte(crc8_byte(cfg.crc_seed, rq.msb_byte), rq.lsb_byte);
            if (crc != rq.crc_byte) begin
              res.step_ok = 1'b0;
              res.checksum_bad = 1'b1;
            end else if ((rq.lsb_byte & cfg.status_mask) == cfg.status_mask) begin
              hum_code = {rq.msb_byte, rq.lsb_byte & ~cfg.status_mask};
            end else begin
              temp_code = {rq.msb_byte, rq.lsb_byte};
            end
          end
          cur_phase = (cur_phase == PhCodeTemp) ? PhCodeHum : PhCodeIdle;
          first_entry = 1'b1;
        end
      end else if (cur_phase == PhCodeIdle) begin
        if (first_entry) begin
          elapsed_total = '0;
          first_entry = 1'b0;
        end else if (elapsed_total >= cfg.cycle_ms) begin
          cur_phase = PhCodeTemp;
          first_entry = 1'b1;
        end
      end else begin
        res.step_ok = 1'b0;
      end
    end
    res.temp_code = temp_code;
    res.hum_code = hum_code;
    res.phase = cur_phase;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t   want;
    poll_req_t rq;
    if (!rst_ni) begin
      cfg = '{16'd1000, 8'd50, 8'd16, 8'h31, 8'h00, 8'h02};
      cur_phase = PhCodeIdle;
      first_entry = 1'b1;
      elapsed_total = '0;
      temp_code = '0;
      hum_code = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          RegCycle:    cfg.cycle_ms = pwdata_i[15:0];
          RegTempDly:  cfg.temp_delay_ms = pwdata_i[7:0];
          RegHumDly:   cfg.hum_delay_ms = pwdata_i[7:0];
          RegCrcPoly:  cfg.crc_poly = pwdata_i[7:0];
          RegCrcSeed:  cfg.crc_seed = pwdata_i[7:0];
          RegStatMask: cfg.status_mask = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", res_data_i[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (res_data_i[1:0] !== want.issued_cmd)
            report_mismatch("issued_cmd", 32'(res_data_i[1:0]), 32'(want.issued_cmd));
          if (res_data_i[2] !== want.issued_read)
            report_mismatch("issued_read", 32'(res_data_i[2]), 32'(want.issued_read));
          if (res_data_i[3] !== want.step_ok)
            report_mismatch("step_ok", 32'(res_data_i[3]), 32'(want.step_ok));
          if (res_data_i[4] !== want.checksum_bad)
            report_mismatch("checksum_bad", 32'(res_data_i[4]), 32'(want.checksum_bad));
          if (res_data_i[20:5] !== want.temp_code)
            report_mismatch("temp_code", 32'(res_data_i[20:5]), 32'(want.temp_code));
          if (res_data_i[36:21] !== want.hum_code)
            report_mismatch("hum_code", 32'(res_data_i[36:21]), 32'(want.hum_code));
          if (res_data_i[38:37] !== want.phase)
            report_mismatch("phase", 32'(res_data_i[38:37]), 32'(want.phase));
        end
      end
      if (req_valid_i && req_ready_i) begin
        rq = poll_req_t'(req_data_i[$bits(poll_req_t)-1:0]);
        predict_poll(rq, want);
        expected_results.push_back(want);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: test/humidity_sensor_poll_sequencer_core_test.sv
module humidity_sensor_poll_sequencer_core_test;
  import hsps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // elapsed_ms, write_ok, read_ok, msb_byte, lsb_byte, crc_byte (from bit 0 up)
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // issued_cmd, issued_read, step_ok, checksum_bad, temp_code, hum_code, phase
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  logic [7:0]  stim_poly = 8'h31;
  logic [7:0]  stim_seed = 8'h00;
  logic [7:0]  stim_mask = 8'h02;

  humidity_sensor_poll_sequencer_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  poll_result_checker checker_i (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready), .req_data_i(s_axis_tdata),
    .res_valid_i(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_data_i(m_axis_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic logic [7:0] frame_checksum(input logic [7:0] msb, input logic [7:0] lsb);
    logic [7:0] c;
    c = stim_seed;
    for (int n = 0; n < 16; n++) begin
      if (n == 0) c ^= msb;
      if (n == 8) c ^= lsb;
      c = {c[6:0], 1'b0} ^ (c[7] ? stim_poly : 8'h00);
    end
    return c;
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_settings(input logic [15:0] cycle, input logic [7:0] tdly,
                                  input logic [7:0] hdly, input logic [7:0] poly,
                                  input logic [7:0] seed, input logic [7:0] mask);
    write_register(RegCycle, 32'(cycle));
    write_register(RegTempDly, 32'(tdly));
    write_register(RegHumDly, 32'(hdly));
    write_register(RegCrcPoly, 32'(poly));
    write_register(RegCrcSeed, 32'(seed));
    write_register(RegStatMask, 32'(mask));
    stim_poly = poly;
    stim_seed = seed;
    stim_mask = mask;
  endtask

  task automatic send_poll(input logic [15:0] elapsed, input logic wok, input logic rok,
                           input logic [7:0] msb, input logic [7:0] lsb,
                           input logic [7:0] chk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, chk, lsb, msb, rok, wok, elapsed};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random_poll();
    logic [15:0] elapsed;
    logic [7:0]  msb;
    logic [7:0]  lsb;
    logic [7:0]  chk;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) elapsed = '0;
    else if (r < 55) elapsed = 16'($urandom_range(300, 1));
    else if (r < 90) elapsed = 16'($urandom_range(65535, 256));
    else elapsed = 16'hFFFF;
    msb = 8'($urandom);
    lsb = 8'($urandom);
    if ($urandom_range(1) == 1) lsb |= stim_mask;
    else lsb &= ~stim_mask;
    chk = frame_checksum(msb, lsb);
    if ($urandom_range(99) < 25) chk ^= 8'($urandom_range(255, 1));
    send_poll(elapsed, $urandom_range(99) < 75, $urandom_range(99) < 85, msb, lsb, chk);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_poll(16'd0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_poll(16'd1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd999, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd5, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd49, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
    send_poll(16'd1, 1'b1, 1'b0, 8'h12, 8'h36, frame_checksum(8'h12, 8'h36));
    send_poll(16'd3, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd16, 1'b0, 1'b1, 8'h12, 8'h36, frame_checksum(8'h12, 8'h36));
    send_poll(16'd1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd1000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd50, 1'b0, 1'b1, 8'hA5, 8'h5A, frame_checksum(8'hA5, 8'h5A) ^ 8'h5A);
    send_poll(16'd1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd20, 1'b0, 1'b1, 8'hFF, 8'hFF, frame_checksum(8'hFF, 8'hFF));
    send_poll(16'd1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd50, 1'b0, 1'b1, 8'h00, 8'h00, frame_checksum(8'h00, 8'h00));
    send_poll(16'd1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
    send_poll(16'd16, 1'b0, 1'b1, 8'hFF, 8'hFD, frame_checksum(8'hFF, 8'hFD));
    wait_for_results();

    for (int setting = 0; setting < 4; setting++) begin
      case (setting)
        0: program_settings(16'd0, 8'd0, 8'd0, 8'h00, 8'hFF, 8'h00);
        1: program_settings(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        2: program_settings(16'd1000, 8'd50, 8'd16, 8'h31, 8'h00, 8'h02);
        default: program_settings(16'($urandom_range(3000)), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom),
                                  8'(1 << $urandom_range(7)));
      endcase
      for (int idling = 0; idling < 4; idling++) begin
        case (idling)
          0: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
          end
          1: begin
            sender_idle_pct = 73;
            receiver_stall_pct = 0;
          end
          2: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 73;
          end
          default: begin
            sender_idle_pct = 23;
            receiver_stall_pct = 23;
          end
        endcase
        repeat (58) send_random_poll();
        wait_for_results();
      end
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/hsps_pkg.sv
src/hsps_crc8_byte.sv
src/hsps_step.sv
src/humidity_sensor_poll_sequencer_core.sv
test/poll_result_checker.sv
test/humidity_sensor_poll_sequencer_core_test.sv
